FILE: design/awa_pkg.sv
// Package for the Ackermann wheel angle block: fixed-point widths, angle constants,
// CORDIC arctangent table and the payload types carried between the cells.
// No dependencies.
`default_nettype none

package awa_pkg;

   // Internal widths: angles Q30, rotation vector Q30, vectoring vector Q42
   localparam int ZW = 34;
   localparam int RW = 32;
   localparam int LW = 16;
   localparam int WW = 15;
   localparam int PW = LW + 1 + RW;
   localparam int VW = 50;
   localparam int OW = 16;

   // Angle constants in Q30
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam logic signed [ZW-1:0] HALF_PI_Z = 34'sd1686629713;
   localparam logic signed [RW-1:0] GAIN_Q30  = 32'sd652032874;

   // Reset values of the configuration registers
   localparam logic [LW-1:0] WHEELBASE_RST  = 16'd10158;
   localparam logic [WW-1:0] HALF_TRACK_RST = 15'd430;

   // Configuration register indexes
   localparam logic CSR_WHEELBASE  = 1'b0;
   localparam logic CSR_HALF_TRACK = 1'b1;

   typedef struct packed {
      logic                   zero;
      logic signed [RW-1:0]   x;
      logic signed [RW-1:0]   y;
      logic signed [ZW-1:0]   z;
   } rot_data_type;

   typedef struct packed {
      logic signed [VW-1:0]   x;
      logic signed [VW-1:0]   y;
      logic signed [ZW-1:0]   z;
   } lane_type;

   typedef struct packed {
      logic       zero;
      lane_type   left;
      lane_type   right;
   } vec_data_type;

   // atan(2^-i) in Q30
   function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
      logic signed [ZW-1:0] r;
      case (i)
         0:       r = 34'sh03243F6A8;
         1:       r = 34'sh01DAC6705;
         2:       r = 34'sh00FADBAFC;
         3:       r = 34'sh007F56EA6;
         4:       r = 34'sh003FEAB76;
         5:       r = 34'sh001FFD55B;
         6:       r = 34'sh000FFFAAA;
         7:       r = 34'sh0007FFF55;
         8:       r = 34'sh0003FFFEA;
         9:       r = 34'sh0001FFFFD;
         10:      r = 34'sh0000FFFFF;
         11:      r = 34'sh00007FFFF;
         12:      r = 34'sh00003FFFF;
         13:      r = 34'sh00001FFFF;
         14:      r = 34'sh00000FFFF;
         15:      r = 34'sh000007FFF;
         16:      r = 34'sh000003FFF;
         17:      r = 34'sh000001FFF;
         18:      r = 34'sh000000FFF;
         19:      r = 34'sh0000007FF;
         20:      r = 34'sh0000003FF;
         21:      r = 34'sh0000001FF;
         22:      r = 34'sh0000000FF;
         23:      r = 34'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/awa_rot_cell.sv
// One rotation-mode CORDIC cell: turns the vector towards the residual angle.
// Depends on awa_pkg.
`default_nettype none

module awa_rot_cell
   import awa_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_i,
   output logic         ready_o,
   input  rot_data_type data_i,
   output logic         valid_o,
   input  logic         ready_i,
   output rot_data_type data_o
);

   logic                 valid_ff;
   rot_data_type         data_ff;
   rot_data_type         data_in;
   logic signed [RW-1:0] dx;
   logic signed [RW-1:0] dy;

   // Take a new request whenever the cell is empty or being drained
   assign ready_o = !valid_ff || ready_i;
   assign valid_o = valid_ff;
   assign data_o  = data_ff;

   // Rotate by +/- atan(2^-STAGE), direction from the sign of the residual
   always_comb begin
      data_in = data_i;
      dx = data_i.y >>> STAGE;
      dy = data_i.x >>> STAGE;
      if (!data_i.z[ZW-1]) begin
         data_in.x = data_i.x - dx;
         data_in.y = data_i.y + dy;
         data_in.z = data_i.z - atan_q30(STAGE);
      end else begin
         data_in.x = data_i.x + dx;
         data_in.y = data_i.y - dy;
         data_in.z = data_i.z + atan_q30(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/awa_vec_cell.sv
// One vectoring-mode CORDIC cell for both wheels: drives y towards zero and
// accumulates the angle. Depends on awa_pkg.
`default_nettype none

module awa_vec_cell
   import awa_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid_i,
   output logic         ready_o,
   input  vec_data_type data_i,
   output logic         valid_o,
   input  logic         ready_i,
   output vec_data_type data_o
);

   logic         valid_ff;
   vec_data_type data_ff;
   vec_data_type data_in;

   // One micro-rotation of a lane
   function automatic lane_type vec_step(input lane_type l);
      lane_type             r;
      logic signed [VW-1:0] dx;
      logic signed [VW-1:0] dy;
      dx = l.y >>> STAGE;
      dy = l.x >>> STAGE;
      if (l.y[VW-1]) begin
         r.x = l.x - dx;
         r.y = l.y + dy;
         r.z = l.z - atan_q30(STAGE);
      end else begin
         r.x = l.x + dx;
         r.y = l.y - dy;
         r.z = l.z + atan_q30(STAGE);
      end
      return r;
   endfunction

   assign ready_o = !valid_ff || ready_i;
   assign valid_o = valid_ff;
   assign data_o  = data_ff;

   // Advance both lanes side by side
   always_comb begin
      data_in.zero  = data_i.zero;
      data_in.left  = vec_step(data_i.left);
      data_in.right = vec_step(data_i.right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && ready_o) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/awa_geom.sv
// Geometry stages between the two CORDIC chains: scale sin/cos by wheelbase and
// offset, form both wheel vectors, fold them into the right half-plane.
// Depends on awa_pkg.
`default_nettype none

module awa_geom
   import awa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [LW-1:0] wheelbase,
   input  logic [WW-1:0] half_track_offset,
   input  logic          valid_i,
   output logic          ready_o,
   input  rot_data_type  data_i,
   output logic          valid_o,
   input  logic          ready_i,
   output vec_data_type  data_o
);

   typedef struct packed {
      logic                 zero;
      logic signed [PW-1:0] lx;
      logic signed [PW-1:0] wy;
      logic signed [PW-1:0] ly;
   } prod_type;

   typedef struct packed {
      logic                 zero;
      logic signed [VW-1:0] lx;
      logic signed [VW-1:0] rx;
      logic signed [VW-1:0] ly;
   } sum_type;

   logic                 prod_valid_ff;
   logic                 sum_valid_ff;
   logic                 fold_valid_ff;
   prod_type             prod_ff;
   prod_type             prod_in;
   sum_type              sum_ff;
   sum_type              sum_in;
   vec_data_type         fold_ff;
   vec_data_type         fold_in;
   logic                 prod_ready;
   logic                 sum_ready;
   logic                 fold_ready;
   logic signed [LW:0]   l_s;
   logic signed [WW:0]   w_s;

   // Rotate by a quarter turn when x is negative so the chain converges
   function automatic lane_type fold(input logic signed [VW-1:0] x,
                                     input logic signed [VW-1:0] y);
      lane_type r;
      if (x[VW-1]) begin
         if (!y[VW-1]) begin
            r.x = y;
            r.y = -x;
            r.z = HALF_PI_Z;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -HALF_PI_Z;
         end
      end else begin
         r.x = x;
         r.y = y;
         r.z = '0;
      end
      return r;
   endfunction

   assign fold_ready = !fold_valid_ff || ready_i;
   assign sum_ready  = !sum_valid_ff || fold_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign ready_o    = prod_ready;
   assign valid_o    = fold_valid_ff;
   assign data_o     = fold_ff;

   // Products: L*cos, W*sin, L*sin
   always_comb begin
      l_s = {1'b0, wheelbase};
      w_s = {1'b0, half_track_offset};
      prod_in.zero = data_i.zero;
      prod_in.lx   = PW'(l_s) * PW'(data_i.x);
      prod_in.wy   = PW'(w_s) * PW'(data_i.y);
      prod_in.ly   = PW'(l_s) * PW'(data_i.y);
   end

   // Wheel vectors: left subtracts the offset term, right adds it
   always_comb begin
      sum_in.zero = prod_ff.zero;
      sum_in.lx   = VW'(prod_ff.lx) - VW'(prod_ff.wy);
      sum_in.rx   = VW'(prod_ff.lx) + VW'(prod_ff.wy);
      sum_in.ly   = VW'(prod_ff.ly);
   end

   always_comb begin
      fold_in.zero  = sum_ff.zero;
      fold_in.left  = fold(sum_ff.lx, sum_ff.ly);
      fold_in.right = fold(sum_ff.rx, sum_ff.ly);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         fold_valid_ff <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= valid_i;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
         if (fold_ready) begin
            fold_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i && prod_ready) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff && sum_ready) begin
         sum_ff <= sum_in;
      end
      if (sum_valid_ff && fold_ready) begin
         fold_ff <= fold_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ackermann_wheel_angles.sv
// Top level of the Ackermann front wheel angle block: input saturation, rotation
// CORDIC chain, geometry stages, vectoring CORDIC chain and output rounding.
// Depends on awa_pkg, awa_rot_cell, awa_vec_cell and awa_geom.
//
//   channel   ports                                   direction
//   request   req_valid req_ready req_steer_angle     in
//   response  rsp_valid rsp_ready rsp_left_angle      out
//             rsp_right_angle
//   csr       csr_valid csr_ready csr_index csr_wdata in
//
// One request is taken per cycle while no stall holds the pipeline; each passes through
// the two CORDIC cell chains plus five single stages.
// Every stage holds its own valid bit, so a stalled response only stops the
// stages behind it once they fill; empty stages keep taking requests.
// Reset is synchronous and clears the valid bits and loads the register defaults.
`default_nettype none

module ackermann_wheel_angles
   import awa_pkg::*;
#(
   parameter int CORDIC_STAGES   = 16,
   parameter int ANGLE_FRAC_BITS = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [14:0]   req_steer_angle,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [OW-1:0] rsp_left_angle,
   output logic signed [OW-1:0] rsp_right_angle,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [LW-1:0]        csr_wdata
);

   localparam int     S         = 30 - ANGLE_FRAC_BITS;
   localparam longint HALF      = 64'sd1 <<< (S - 1);
   localparam longint LIM_IN_L  = (HALF_PI_Q30 + HALF) >>> S;
   localparam longint LIM_OUT_L = (PI_Q30 + HALF) >>> S;
   localparam logic signed [31:0]   LIM_IN  = 32'(LIM_IN_L);
   localparam logic signed [ZW-1:0] LIM_OUT = ZW'(LIM_OUT_L);
   localparam logic signed [ZW-1:0] HALF_Z  = ZW'(HALF);

   logic [LW-1:0]         wheelbase_ff;
   logic [WW-1:0]         half_track_offset_ff;

   logic                  sat_valid_ff;
   rot_data_type          sat_ff;
   rot_data_type          sat_in;
   logic signed [31:0]    a_ext;
   logic signed [31:0]    a_sat;

   rot_data_type          rot_data  [CORDIC_STAGES+1];
   logic                  rot_valid [CORDIC_STAGES+1];
   logic                  rot_ready [CORDIC_STAGES+1];
   vec_data_type          vec_data  [CORDIC_STAGES+1];
   logic                  vec_valid [CORDIC_STAGES+1];
   logic                  vec_ready [CORDIC_STAGES+1];

   logic                  out_valid_ff;
   logic signed [OW-1:0]  left_ff;
   logic signed [OW-1:0]  right_ff;
   logic signed [OW-1:0]  left_in;
   logic signed [OW-1:0]  right_in;

   // Q30 angle to output fraction bits, half away from zero, clamped to +/-pi
   function automatic logic signed [OW-1:0] to_out(input logic signed [ZW-1:0] v);
      logic signed [ZW-1:0] r;
      logic signed [ZW-1:0] m;
      if (!v[ZW-1]) begin
         r = (v + HALF_Z) >>> S;
      end else begin
         m = -v;
         r = -((m + HALF_Z) >>> S);
      end
      if (r > LIM_OUT) begin
         r = LIM_OUT;
      end
      if (r < -LIM_OUT) begin
         r = -LIM_OUT;
      end
      return r[OW-1:0];
   endfunction

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff         <= WHEELBASE_RST;
         half_track_offset_ff <= HALF_TRACK_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WHEELBASE:  wheelbase_ff         <= csr_wdata;
            CSR_HALF_TRACK: half_track_offset_ff <= csr_wdata[WW-1:0];
            default:        wheelbase_ff         <= wheelbase_ff;
         endcase
      end
   end

   // Saturate the request to +/-pi/2 and seed the rotation vector
   always_comb begin
      a_ext = 32'(req_steer_angle);
      a_sat = a_ext;
      if (a_ext > LIM_IN) begin
         a_sat = LIM_IN;
      end
      if (a_ext < -LIM_IN) begin
         a_sat = -LIM_IN;
      end
      sat_in.zero = (a_sat == '0);
      sat_in.x    = GAIN_Q30;
      sat_in.y    = '0;
      sat_in.z    = ZW'(a_sat) <<< S;
   end

   assign req_ready = !sat_valid_ff || rot_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff <= 1'b0;
      end else if (req_ready) begin
         sat_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sat_ff <= sat_in;
      end
   end

   assign rot_data[0]  = sat_ff;
   assign rot_valid[0] = sat_valid_ff;

   // Rotation chain: sin and cos of the steering angle
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
      awa_rot_cell #(
         .STAGE (g)
      ) u_rot_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (rot_valid[g]),
         .ready_o (rot_ready[g]),
         .data_i  (rot_data[g]),
         .valid_o (rot_valid[g+1]),
         .ready_i (rot_ready[g+1]),
         .data_o  (rot_data[g+1])
      );
   end

   awa_geom u_geom (
      .clock             (clock),
      .reset             (reset),
      .wheelbase         (wheelbase_ff),
      .half_track_offset (half_track_offset_ff),
      .valid_i           (rot_valid[CORDIC_STAGES]),
      .ready_o           (rot_ready[CORDIC_STAGES]),
      .data_i            (rot_data[CORDIC_STAGES]),
      .valid_o           (vec_valid[0]),
      .ready_i           (vec_ready[0]),
      .data_o            (vec_data[0])
   );

   // Vectoring chain: atan2 of both wheel vectors
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      awa_vec_cell #(
         .STAGE (g)
      ) u_vec_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (vec_valid[g]),
         .ready_o (vec_ready[g]),
         .data_i  (vec_data[g]),
         .valid_o (vec_valid[g+1]),
         .ready_i (vec_ready[g+1]),
         .data_o  (vec_data[g+1])
      );
   end

   // Output register: round, clamp, force zero for a straight-ahead request
   assign vec_ready[CORDIC_STAGES] = !out_valid_ff || rsp_ready;

   always_comb begin
      if (vec_data[CORDIC_STAGES].zero) begin
         left_in  = '0;
         right_in = '0;
      end else begin
         left_in  = to_out(vec_data[CORDIC_STAGES].left.z);
         right_in = to_out(vec_data[CORDIC_STAGES].right.z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (vec_ready[CORDIC_STAGES]) begin
         out_valid_ff <= vec_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (vec_valid[CORDIC_STAGES] && vec_ready[CORDIC_STAGES]) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_angle  = left_ff;
   assign rsp_right_angle = right_ff;

endmodule

`default_nettype wire
